@@ hdl/bsc_pkg.sv @@
// Shared types and constants for the banker's safety check block.
// Holds the transaction structs, the action codes and the controller/datapath
// command and status structs. No dependencies.
package bsc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_PROCS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 16;

  // Fixed field widths of the transactions.
  localparam int MAX_ROWS = 16;
  localparam int FIELD_W  = 16;
  localparam int WORK_W   = 20;
  localparam int NTYPES   = 3;
  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  // Action codes of an input transaction.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic               action;
    logic [3:0]         proc_index;
    logic [FIELD_W-1:0] max_a;
    logic [FIELD_W-1:0] max_b;
    logic [FIELD_W-1:0] max_c;
    logic [FIELD_W-1:0] held_a;
    logic [FIELD_W-1:0] held_b;
    logic [FIELD_W-1:0] held_c;
    logic [FIELD_W-1:0] free_a;
    logic [FIELD_W-1:0] free_b;
    logic [FIELD_W-1:0] free_c;
    logic [4:0]         proc_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        granted_proc;
    logic [3:0]        order_pos;
    logic              is_safe;
    logic              last;
    logic [WORK_W-1:0] work_a;
    logic [WORK_W-1:0] work_b;
    logic [WORK_W-1:0] work_c;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // store one process row
    logic init;   // start a check from the available vector
    logic probe;  // examine the process under the scan pointer
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // the offered check has no processes
    logic finish;      // the current probe ends the check
  } dp_status_t;

endpackage

@@ hdl/bankers_safety_check.sv @@
// Banker's safety check over three resource types, top level.
// Depends on bsc_pkg, bsc_ctrl, bsc_datapath and bsc_ram.
//
// Usage: a transaction is taken at a rising edge with start high and busy
// low. A load transaction (action 0) writes one process row (need and held)
// into the table in that cycle and leaves busy low. A check transaction
// (action 1) loads the work vector from the free fields and scans processes
// 0 to n-1 round robin, n being proc_count limited to the table size, one
// probe per cycle, while busy is high. Each admitted process gives one
// result in the cycle after its probe: a single-cycle out_strobe with
// out_data. A check ends with the result that has last set; it is either
// the final safe entry or one unsafe entry, given when n probes in a row
// admit no process. The probe loop reads one table row per cycle through
// the table's read port.
// A check with proc_count zero gives no result and leaves busy low.
// Reset clears the controller, counters, finished mask and work vector; the
// table holds no defined contents until rows are loaded. The receiver has
// no way to stall results: each is valid for exactly its strobe cycle.
module bankers_safety_check #(
  parameter int MAX_PROCS   = bsc_pkg::MAX_PROCS_DEF,
  parameter int VALUE_WIDTH = bsc_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bsc_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output bsc_pkg::out_item_t out_data
);
  import bsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer for loads and the probe loop.
  bsc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Table, work vector and result register.
  bsc_datapath #(
    .MAX_PROCS   (MAX_PROCS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

@@ hdl/bsc_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
// One write and one read address per cycle. No dependencies.
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bsc_ctrl.sv @@
// Controller of the banker's safety check: idle and scan states.
// Depends on bsc_pkg for the command and status structs and action codes.
module bsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                action,
  input  bsc_pkg::dp_status_t status,
  output bsc_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import bsc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.init = 1'b1;
            if (!status.count_zero) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.probe = 1'b1;
        if (status.finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ hdl/bsc_datapath.sv @@
// Datapath of the banker's safety check: process table, work vector,
// finished mask, scan pointer and counters, and the result register.
// Depends on bsc_pkg and bsc_ram.
module bsc_datapath #(
  parameter int MAX_PROCS   = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsc_pkg::in_item_t   in_data,
  input  bsc_pkg::dp_cmd_t    cmd,
  output bsc_pkg::dp_status_t status,
  output logic                out_strobe,
  output bsc_pkg::out_item_t  out_data
);
  import bsc_pkg::*;

  localparam int ROWS = (MAX_PROCS < MAX_ROWS) ? MAX_PROCS : MAX_ROWS;
  localparam int AW   = $clog2(ROWS);
  localparam int CW   = $clog2(ROWS + 1);
  localparam int SW   = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int RW   = 2 * NTYPES * SW;

  // Scan state.
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     gcnt_r, gcnt_nxt;
  logic [CW-1:0]     idle_r, idle_nxt;
  logic [ROWS-1:0]   fin_r, fin_nxt;
  logic [WORK_W-1:0] work_r [NTYPES];
  logic [WORK_W-1:0] work_nxt [NTYPES];
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Table port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic [SW-1:0]     in_max [NTYPES];
  logic [SW-1:0]     in_held [NTYPES];
  logic [SW-1:0]     in_free [NTYPES];
  logic [SW-1:0]     row_need [NTYPES];
  logic [SW-1:0]     row_held [NTYPES];
  logic [WORK_W:0]   sum [NTYPES];
  logic [WORK_W-1:0] sat [NTYPES];
  logic [CW-1:0]     n_in;
  logic [AW-1:0]     ptr_adv;
  logic              row_ok;
  logic              fits;
  logic              ok;
  logic              last_safe;
  logic              give_up;

  // Input fields reduced to the stored value width.
  always_comb begin
    in_max[0]  = in_data.max_a[SW-1:0];
    in_max[1]  = in_data.max_b[SW-1:0];
    in_max[2]  = in_data.max_c[SW-1:0];
    in_held[0] = in_data.held_a[SW-1:0];
    in_held[1] = in_data.held_b[SW-1:0];
    in_held[2] = in_data.held_c[SW-1:0];
    in_free[0] = in_data.free_a[SW-1:0];
    in_free[1] = in_data.free_b[SW-1:0];
    in_free[2] = in_data.free_c[SW-1:0];
  end

  // Row write: need is max minus held, clamped at zero.
  always_comb begin
    for (int t = 0; t < NTYPES; t++) begin
      ram_wdata[RW-1-t*SW -: SW] = (in_max[t] > in_held[t]) ?
                                   (in_max[t] - in_held[t]) : '0;
      ram_wdata[NTYPES*SW-1-t*SW -: SW] = in_held[t];
    end
  end

  assign row_ok    = ({1'b0, in_data.proc_index} < 5'(ROWS));
  assign ram_we    = cmd.load && row_ok;
  assign ram_waddr = AW'(in_data.proc_index);

  // Process count, limited to the table size.
  assign n_in = (in_data.proc_count > 5'(ROWS)) ? CW'(ROWS) : CW'(in_data.proc_count);
  assign status.count_zero = (in_data.proc_count == 5'd0);

  // The pointer always advances, so the next row is fetched during each probe.
  assign ptr_adv   = ((CW'(ptr_r) + CW'(1)) >= n_r) ? '0 : (ptr_r + AW'(1));
  assign ram_raddr = cmd.probe ? ptr_adv : '0;

  bsc_ram #(
    .WIDTH (RW),
    .DEPTH (ROWS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Probe: compare need with work and form the saturated sums.
  always_comb begin
    fits = 1'b1;
    for (int t = 0; t < NTYPES; t++) begin
      row_need[t] = ram_rdata[RW-1-t*SW -: SW];
      row_held[t] = ram_rdata[NTYPES*SW-1-t*SW -: SW];
      if (WORK_W'(row_need[t]) > work_r[t]) begin
        fits = 1'b0;
      end
      sum[t] = {1'b0, work_r[t]} + (WORK_W+1)'(row_held[t]);
      sat[t] = sum[t][WORK_W] ? WORK_MAX : sum[t][WORK_W-1:0];
    end
  end

  assign ok        = !fin_r[ptr_r] && fits;
  assign last_safe = ok && ((gcnt_r + CW'(1)) == n_r);
  assign give_up   = !ok && ((idle_r + CW'(1)) >= n_r);
  assign status.finish = last_safe || give_up;

  // Next values of the scan state and the result register.
  always_comb begin
    ptr_nxt        = ptr_r;
    n_nxt          = n_r;
    gcnt_nxt       = gcnt_r;
    idle_nxt       = idle_r;
    fin_nxt        = fin_r;
    work_nxt       = work_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (cmd.init) begin
      ptr_nxt  = '0;
      n_nxt    = n_in;
      gcnt_nxt = '0;
      idle_nxt = '0;
      fin_nxt  = '0;
      for (int t = 0; t < NTYPES; t++) begin
        work_nxt[t] = WORK_W'(in_free[t]);
      end
    end else if (cmd.probe) begin
      ptr_nxt = ptr_adv;
      if (ok) begin
        fin_nxt[ptr_r] = 1'b1;
        work_nxt       = sat;
        gcnt_nxt       = gcnt_r + CW'(1);
        idle_nxt       = '0;
      end else begin
        idle_nxt = idle_r + CW'(1);
      end
      out_strobe_nxt = ok || give_up;
      out_data_nxt.granted_proc = ok ? 4'(ptr_r) : 4'd0;
      out_data_nxt.order_pos    = 4'(gcnt_r);
      out_data_nxt.is_safe      = ok;
      out_data_nxt.last         = ok ? last_safe : 1'b1;
      out_data_nxt.work_a       = ok ? sat[0] : work_r[0];
      out_data_nxt.work_b       = ok ? sat[1] : work_r[1];
      out_data_nxt.work_c       = ok ? sat[2] : work_r[2];
    end
  end

  // Control registers are reset; the result payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      n_r          <= '0;
      gcnt_r       <= '0;
      idle_r       <= '0;
      fin_r        <= '0;
      out_strobe_r <= 1'b0;
      for (int t = 0; t < NTYPES; t++) begin
        work_r[t] <= '0;
      end
    end else begin
      ptr_r        <= ptr_nxt;
      n_r          <= n_nxt;
      gcnt_r       <= gcnt_nxt;
      idle_r       <= idle_nxt;
      fin_r        <= fin_nxt;
      out_strobe_r <= out_strobe_nxt;
      work_r       <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

@@ sim/tb_bankers_safety_check.sv @@
// Self-checking testbench for the banker's safety check block.
// Loads process rows, runs safety checks and compares every result, safe or
// unsafe, with an in-bench scoreboard. Depends on bsc_pkg and bankers_safety_check.
module tb_bankers_safety_check;
  import bsc_pkg::*;

  // Cycles without any accepted transaction or result before the run is abandoned.
  localparam int QUIET_LIMIT  = 4000;
  // Settling time after the last expected result, longer than a full check.
  localparam int DRAIN_CYCLES = 300;

  // Value styles used to fill process rows and available vectors.
  localparam int STYLE_SMALL   = 0;
  localparam int STYLE_FULL    = 1;
  localparam int STYLE_EXTREME = 2;

  // Scoreboard: keeps its own copy of the process table and predicts the
  // safe order that each check transaction produces.
  class safety_scoreboard;
    bit [FIELD_W-1:0] need_rows [MAX_ROWS][NTYPES];
    bit [FIELD_W-1:0] held_rows [MAX_ROWS][NTYPES];
    out_item_t        order_q[$];
    int               fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int pending();
      return order_q.size();
    endfunction

    // Record an accepted input transaction and queue the results it causes.
    function void note_input(in_item_t it);
      bit [FIELD_W-1:0] mx[NTYPES];
      bit [FIELD_W-1:0] hd[NTYPES];
      bit [FIELD_W-1:0] fr[NTYPES];
      bit [WORK_W-1:0]  work[NTYPES];
      bit [WORK_W:0]    sum;
      bit [MAX_ROWS-1:0] done_mask;
      int unsigned      n, ptr, granted, idle, p;
      bit               ok;
      out_item_t        res;
      mx = '{it.max_a, it.max_b, it.max_c};
      hd = '{it.held_a, it.held_b, it.held_c};
      fr = '{it.free_a, it.free_b, it.free_c};

      // A load stores held and the clamped need of one row.
      if (it.action == ACT_LOAD) begin
        for (int t = 0; t < NTYPES; t++) begin
          held_rows[it.proc_index][t] = hd[t];
          need_rows[it.proc_index][t] = (mx[t] > hd[t]) ? mx[t] - hd[t] : '0;
        end
        return;
      end

      // A check scans the first n rows round robin from row zero.
      n = it.proc_count;
      if (n > MAX_PROCS_DEF) n = MAX_PROCS_DEF;
      for (int t = 0; t < NTYPES; t++) work[t] = WORK_W'(fr[t]);
      if (n == 0) return;
      done_mask = '0;
      ptr = 0;
      granted = 0;
      idle = 0;
      while (granted < n) begin
        p = ptr;
        ok = !done_mask[p];
        for (int t = 0; t < NTYPES; t++)
          if (need_rows[p][t] > work[t]) ok = 1'b0;
        if (ok) begin
          done_mask[p] = 1'b1;
          for (int t = 0; t < NTYPES; t++) begin
            sum = {1'b0, work[t]} + (WORK_W+1)'(held_rows[p][t]);
            work[t] = (sum > WORK_MAX) ? WORK_MAX : sum[WORK_W-1:0];
          end
          res.granted_proc = p[3:0];
          res.order_pos    = granted[3:0];
          res.is_safe      = 1'b1;
          res.last         = (granted + 1 == n);
          res.work_a       = work[0];
          res.work_b       = work[1];
          res.work_c       = work[2];
          order_q.push_back(res);
          granted++;
          idle = 0;
        end else begin
          idle++;
        end
        ptr = (p + 1 >= n) ? 0 : p + 1;
        // A full pass without progress ends the check as unsafe.
        if (granted < n && idle >= n) begin
          res.granted_proc = '0;
          res.order_pos    = granted[3:0];
          res.is_safe      = 1'b0;
          res.last         = 1'b1;
          res.work_a       = work[0];
          res.work_b       = work[1];
          res.work_c       = work[2];
          order_q.push_back(res);
          break;
        end
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        fail_count++;
      end
    endfunction

    // Compare one result transaction with the oldest expected entry.
    function void check_result(out_item_t got);
      out_item_t want;
      if (order_q.size() == 0) begin
        $error("unexpected result: granted_proc %0d order_pos %0d",
               got.granted_proc, got.order_pos);
        fail_count++;
        return;
      end
      want = order_q.pop_front();
      compare_field("granted_proc", want.granted_proc, got.granted_proc);
      compare_field("order_pos", want.order_pos, got.order_pos);
      compare_field("is_safe", want.is_safe, got.is_safe);
      compare_field("last", want.last, got.last);
      compare_field("work_a", want.work_a, got.work_a);
      compare_field("work_b", want.work_b, got.work_b);
      compare_field("work_c", want.work_c, got.work_c);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  safety_scoreboard sb;
  bit steady;

  bankers_safety_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor: every strobe cycle carries one result transaction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_data);
  end

  // Watchdog on cycles in which no transaction moves in either direction.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_bankers_safety_check NOT OK");
    $finish;
  end

  // Random contents in every field; don't-care fields keep this noise.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.action     = 1'($urandom_range(0, 1));
    it.proc_index = 4'($urandom_range(0, 15));
    it.max_a      = 16'($urandom);
    it.max_b      = 16'($urandom);
    it.max_c      = 16'($urandom);
    it.held_a     = 16'($urandom);
    it.held_b     = 16'($urandom);
    it.held_c     = 16'($urandom);
    it.free_a     = 16'($urandom);
    it.free_b     = 16'($urandom);
    it.free_c     = 16'($urandom);
    it.proc_count = 5'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic in_item_t load_item(int idx, logic [15:0] mxa, logic [15:0] mxb,
                                         logic [15:0] mxc, logic [15:0] hda,
                                         logic [15:0] hdb, logic [15:0] hdc);
    in_item_t it;
    it = noise_item();
    it.action     = ACT_LOAD;
    it.proc_index = idx[3:0];
    it.max_a      = mxa;
    it.max_b      = mxb;
    it.max_c      = mxc;
    it.held_a     = hda;
    it.held_b     = hdb;
    it.held_c     = hdc;
    return it;
  endfunction

  function automatic in_item_t check_item(int n, logic [15:0] fa, logic [15:0] fb,
                                          logic [15:0] fc);
    in_item_t it;
    it = noise_item();
    it.action     = ACT_CHECK;
    it.proc_count = n[4:0];
    it.free_a     = fa;
    it.free_b     = fb;
    it.free_c     = fc;
    return it;
  endfunction

  function automatic logic [15:0] pick_value(int style);
    logic [15:0] v;
    case (style)
      STYLE_SMALL: begin
        v = 16'($urandom_range(0, 8));
      end
      STYLE_FULL: begin
        v = 16'($urandom);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'h0000;
          1: v = 16'h0001;
          2: v = 16'hFFFE;
          default: v = 16'hFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Hold start low with noise on the data; called at negedge.
  task automatic idle_gap(int cycles);
    start = 1'b0;
    repeat (cycles) begin
      in_data = noise_item();
      @(negedge clk);
    end
  endtask

  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < 14) idle_gap($urandom_range(1, 5));
  endtask

  // Offer one transaction until it is taken; returns at the following negedge
  // with start still high.
  task automatic send_item(in_item_t it);
    maybe_idle();
    start   = 1'b1;
    in_data = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    int rand_items;
    int m;
    int style;
    int n;
    sb      = new();
    steady  = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every row with zero need and full holdings: the work vector saturates.
    for (int i = 0; i < MAX_ROWS; i++)
      send_item(load_item(i, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(check_item(16, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // A check with no processes gives nothing; an oversized count saturates.
    send_item(check_item(0, 16'h0, 16'h0, 16'h0));
    send_item(check_item(31, 16'h0, 16'h0, 16'h0));
    // Row zero needs everything: it is admitted only after row one.
    send_item(load_item(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0));
    send_item(check_item(2, 16'h0, 16'h0, 16'h0));
    // A single process that can never run is unsafe at once.
    send_item(check_item(1, 16'h0, 16'h0, 16'h0));
    // Max below held in two types clamps those needs to zero.
    send_item(load_item(1, 16'hFFFF, 16'h0003, 16'h0000, 16'h0001, 16'h0005, 16'hFFFF));
    send_item(check_item(3, 16'h0, 16'h0, 16'h0));
    send_item(check_item(2, 16'hFFFD, 16'hFFFF, 16'hFFFF));

    // Random scenarios: load the rows of a small system, then check it.
    rand_items = 0;
    while (rand_items < 75) begin
      m = ($urandom_range(0, 9) == 0) ? MAX_ROWS : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1:    style = STYLE_FULL;
        2, 3:    style = STYLE_EXTREME;
        default: style = STYLE_SMALL;
      endcase
      for (int i = 0; i < m; i++) begin
        steady = (rand_items >= 25 && rand_items < 55);
        // Now and then a row is left stale from an earlier scenario.
        if ($urandom_range(0, 5) != 0) begin
          send_item(load_item(i, pick_value(style), pick_value(style), pick_value(style),
                              pick_value(style), pick_value(style), pick_value(style)));
          rand_items++;
        end
      end
      // A stray load into any row between scenarios.
      if ($urandom_range(0, 7) == 0) begin
        send_item(load_item($urandom_range(0, 15), pick_value(STYLE_FULL),
                            pick_value(STYLE_FULL), pick_value(STYLE_FULL),
                            pick_value(STYLE_FULL), pick_value(STYLE_FULL),
                            pick_value(STYLE_FULL)));
        rand_items++;
      end
      steady = (rand_items >= 25 && rand_items < 55);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : m;
      send_item(check_item(n, pick_value(style), pick_value(style), pick_value(style)));
      rand_items++;
    end
    steady = 1'b0;
    start  = 1'b0;

    // Wait for the last results, then let the block settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("tb_bankers_safety_check OK");
    end else begin
      $display("tb_bankers_safety_check NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/bsc_pkg.sv
hdl/bsc_ram.sv
hdl/bsc_ctrl.sv
hdl/bsc_datapath.sv
hdl/bankers_safety_check.sv
sim/tb_bankers_safety_check.sv
